// ===== hw/rtl/pbsb_pkg.sv =====
// Shared constants, register codes and sideband type for the projected box
// screen bounds pipeline. No dependencies.
package pbsb_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int FOC_FRAC      = 16;
  localparam int SAT_LOG2      = 14;
  localparam int POS_W         = 48;
  localparam int RAD_W         = 47;
  localparam int CRD_W         = 49;
  localparam int FOC_W         = 32;
  localparam int SIZE_W        = 13;
  localparam int PIX_W         = 12;

  localparam logic [SIZE_W-1:0] MAX_SIZE   = 13'd4096;
  localparam logic [SIZE_W-1:0] WIDTH_RST  = 13'd1280;
  localparam logic [SIZE_W-1:0] HEIGHT_RST = 13'd720;
  localparam logic [FOC_W-1:0]  FOCAL_RST  = 32'd41943040;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_FOCAL  = 2'd2
  } pbsb_reg_e;

  typedef struct packed {
    logic       behind;
    logic [3:0] c_neg;
    logic [3:0] c_zero;
    logic [1:0] z_neg;
  } pbsb_side_t;

endpackage

// ===== hw/rtl/pbsb_front.sv =====
// Front end: corner sums, magnitudes, focal-length products, dividends and divisors.
// Three register stages. Depends on pbsb_pkg.
module pbsb_front
  import pbsb_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int NSH = (FRAC_BITS > FOC_FRAC) ? FRAC_BITS - FOC_FRAC : 0,
  localparam int DSH = (FRAC_BITS < FOC_FRAC) ? FOC_FRAC - FRAC_BITS : 0,
  localparam int NW  = CRD_W + FOC_W + NSH,
  localparam int DW  = POS_W + DSH
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic signed [POS_W-1:0] pos_x_i,
  input  logic signed [POS_W-1:0] pos_y_i,
  input  logic signed [POS_W-1:0] pos_z_i,
  input  logic        [RAD_W-1:0] radius_i,
  input  logic        [FOC_W-1:0] focal_i,
  output logic                    valid_o,
  output pbsb_side_t              side_o,
  output logic        [NW-1:0]    num_o [4],
  output logic        [DW-1:0]    den_o [2]
);

  logic signed [CRD_W-1:0] c1_d [4];
  logic signed [CRD_W-1:0] z1_d [2];
  logic signed [CRD_W-1:0] c1_q [4];
  logic signed [CRD_W-1:0] z1_q [2];
  logic                    v1_q, v2_q, v3_q;

  logic signed [CRD_W-1:0] px, py, pz, rad;

  always_comb begin
    px  = CRD_W'(pos_x_i);
    py  = CRD_W'(pos_y_i);
    pz  = CRD_W'(pos_z_i);
    rad = signed'({2'b00, radius_i});
    c1_d[0] = px + rad;
    c1_d[1] = px - rad;
    c1_d[2] = py + rad;
    c1_d[3] = py - rad;
    z1_d[0] = pz + rad;
    z1_d[1] = pz - rad;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c1_q <= c1_d;
      z1_q <= z1_d;
    end
  end

  pbsb_side_t      side2_d, side2_q, side3_q;
  logic [63:0]     plo_d [4];
  logic [48:0]     phi_d [4];
  logic [63:0]     plo_q [4];
  logic [48:0]     phi_q [4];
  logic [POS_W-1:0] den2_q [2];
  logic [CRD_W-1:0] mag;

  always_comb begin
    mag     = '0;
    side2_d = '0;
    side2_d.behind = (z1_q[0] <= CRD_W'(0));
    for (int j = 0; j < 2; j++) begin
      side2_d.z_neg[j] = z1_q[j][CRD_W-1];
    end
    for (int k = 0; k < 4; k++) begin
      side2_d.c_neg[k]  = c1_q[k][CRD_W-1];
      side2_d.c_zero[k] = (c1_q[k] == '0);
      mag      = c1_q[k][CRD_W-1] ? CRD_W'(-c1_q[k]) : CRD_W'(c1_q[k]);
      plo_d[k] = {32'b0, mag[31:0]} * {32'b0, focal_i};
      phi_d[k] = {32'b0, mag[48:32]} * {17'b0, focal_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side2_q <= side2_d;
      plo_q   <= plo_d;
      phi_q   <= phi_d;
      for (int j = 0; j < 2; j++) begin
        den2_q[j] <= z1_q[j][POS_W-1:0];
      end
    end
  end

  logic [CRD_W+FOC_W-1:0] sum [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sum[k] = {17'b0, plo_q[k]} + {phi_q[k], 32'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side3_q <= side2_q;
      for (int k = 0; k < 4; k++) begin
        num_o[k] <= NW'(sum[k]) << NSH;
      end
      for (int j = 0; j < 2; j++) begin
        den_o[j] <= DW'(den2_q[j]) << DSH;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  assign valid_o = v3_q;
  assign side_o  = side3_q;

endmodule

// ===== hw/rtl/pbsb_div.sv =====
// Pipelined restoring divider lane: overflow check stage, then one quotient
// bit per stage. Depends on pbsb_pkg.
module pbsb_div
  import pbsb_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int NSH = (FRAC_BITS > FOC_FRAC) ? FRAC_BITS - FOC_FRAC : 0,
  localparam int DSH = (FRAC_BITS < FOC_FRAC) ? FOC_FRAC - FRAC_BITS : 0,
  localparam int NW  = CRD_W + FOC_W + NSH,
  localparam int DW  = POS_W + DSH,
  localparam int QB  = FRAC_BITS + SAT_LOG2 + 1
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QB-1:0] quo_o,
  output logic          sat_o
);

  localparam int NW1 = NW + 1;

  logic [NW-1:0] rem_q [QB];
  logic [DW-1:0] den_q [QB];
  logic [QB-1:0] quo_q [QB+1];
  logic          sat_q [QB+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= num_i;
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      sat_q[0] <= ((num_i >> QB) >= NW'(den_i));
    end
  end

  for (genvar s = 0; s < QB; s++) begin : g_stage
    localparam int K = QB - 1 - s;
    logic [NW:0]   diff;
    logic [QB-1:0] quo_d;

    assign diff = {1'b0, rem_q[s]} - (NW1'(den_q[s]) << K);

    always_comb begin
      quo_d    = quo_q[s];
      quo_d[K] = ~diff[NW];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[s+1] <= quo_d;
        sat_q[s+1] <= sat_q[s];
      end
    end

    if (s < QB - 1) begin : g_fwd
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[s+1] <= diff[NW] ? rem_q[s] : diff[NW-1:0];
          den_q[s+1] <= den_q[s];
        end
      end
    end
  end

  assign quo_o = quo_q[QB];
  assign sat_o = sat_q[QB];

endmodule

// ===== hw/rtl/pbsb_back.sv =====
// Back end: screen coordinates, min/max, culling, clipping and the output
// register. Five register stages. Depends on pbsb_pkg.
module pbsb_back
  import pbsb_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int QB = FRAC_BITS + SAT_LOG2 + 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  pbsb_side_t        side_i,
  input  logic [QB-1:0]     quo_i [8],
  input  logic              sat_i [8],
  input  logic [SIZE_W-1:0] width_i,
  input  logic [SIZE_W-1:0] height_i,
  output logic              valid_o,
  output logic              visible_o,
  output logic [PIX_W-1:0]  rect_x_o,
  output logic [PIX_W-1:0]  rect_y_o,
  output logic [SIZE_W-1:0] rect_w_o,
  output logic [SIZE_W-1:0] rect_h_o
);

  localparam int SW = FRAC_BITS + SAT_LOG2 + 2;
  localparam logic [QB-1:0]        LIM   = QB'(1) << (FRAC_BITS + SAT_LOG2);
  localparam logic signed [SW-1:0] ONE   = SW'(1) << FRAC_BITS;
  localparam logic signed [SW-1:0] HALFQ = SW'(1) << (FRAC_BITS - 1);

  logic v1_q, v2_q, v3_q, v4_q, v5_q;

  logic signed [SW-1:0] wq, hq, wm1, hm1;
  assign wq  = SW'(width_i) << FRAC_BITS;
  assign hq  = SW'(height_i) << FRAC_BITS;
  assign wm1 = SW'(width_i - 13'd1) << FRAC_BITS;
  assign hm1 = SW'(height_i - 13'd1) << FRAC_BITS;

  logic signed [SW-1:0] sc_d [8];
  logic signed [SW-1:0] sc_q [8];
  logic                 behind1_q;
  logic [QB-1:0]        qm;
  logic signed [SW-1:0] mg, off, sz, hf;
  logic                 cn;

  always_comb begin
    qm  = '0;
    mg  = '0;
    off = '0;
    sz  = '0;
    hf  = '0;
    cn  = 1'b0;
    for (int k = 0; k < 8; k++) begin
      qm  = (sat_i[k] || (quo_i[k] > LIM)) ? LIM : quo_i[k];
      mg  = SW'(qm);
      cn  = side_i.c_neg[k>>1];
      off = side_i.c_zero[k>>1] ? '0 : (cn ? -mg : mg);
      sz  = (k < 4) ? wq : hq;
      hf  = SW'((k < 4) ? (width_i >> 1) : (height_i >> 1)) << FRAC_BITS;
      if (side_i.z_neg[k & 1]) begin
        sc_d[k] = cn ? -ONE : sz;
      end else begin
        sc_d[k] = hf + off;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sc_q      <= sc_d;
      behind1_q <= side_i.behind;
    end
  end

  logic signed [SW-1:0] mnx_d, mxx_d, mny_d, mxy_d;
  logic signed [SW-1:0] mnx_q, mxx_q, mny_q, mxy_q;
  logic                 behind2_q;

  always_comb begin
    mnx_d = sc_q[0];
    mxx_d = '0;
    mny_d = sc_q[4];
    mxy_d = '0;
    for (int i = 0; i < 4; i++) begin
      if (sc_q[i] < mnx_d) mnx_d = sc_q[i];
      if (sc_q[i] > mxx_d) mxx_d = sc_q[i];
      if (sc_q[i+4] < mny_d) mny_d = sc_q[i+4];
      if (sc_q[i+4] > mxy_d) mxy_d = sc_q[i+4];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mnx_q     <= mnx_d;
      mxx_q     <= mxx_d;
      mny_q     <= mny_d;
      mxy_q     <= mxy_d;
      behind2_q <= behind1_q;
    end
  end

  logic                 cull3_d, cull3_q;
  logic signed [SW-1:0] mnx3_d, mxx3_d, mny3_d, mxy3_d;
  logic signed [SW-1:0] mnx3_q, mxx3_q, mny3_q, mxy3_q;

  always_comb begin
    cull3_d = behind2_q ||
              (mnx_q < 0 && mxx_q < 0) || (mnx_q > wq && mxx_q > wq) ||
              (mny_q < 0 && mxy_q < 0) || (mny_q > hq && mxy_q > hq);
    mnx3_d = mnx_q;
    if (mnx_q < 0) mnx3_d = '0;
    if (mnx3_d > wm1) mnx3_d = wm1;
    mny3_d = mny_q;
    if (mny_q < 0) mny3_d = '0;
    if (mny3_d > hm1) mny3_d = hm1;
    mxx3_d = (mxx_q > wq) ? wq : mxx_q;
    mxy3_d = (mxy_q > hq) ? hq : mxy_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cull3_q <= cull3_d;
      mnx3_q  <= mnx3_d;
      mxx3_q  <= mxx3_d;
      mny3_q  <= mny3_d;
      mxy3_q  <= mxy3_d;
    end
  end

  logic signed [SW-1:0] dx, dy, cwr, chr;
  logic                 cull4_q;
  logic [PIX_W-1:0]     rx4_q, ry4_q;
  logic [SIZE_W-1:0]    cw4_q, ch4_q;

  always_comb begin
    dx  = mxx3_q - mnx3_q;
    dy  = mxy3_q - mny3_q;
    cwr = (dx + ONE + ONE - SW'(1)) >>> FRAC_BITS;
    chr = (dy + ONE + ONE - SW'(1)) >>> FRAC_BITS;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cull4_q <= cull3_q || (dx < HALFQ) || (dy < HALFQ);
      rx4_q   <= mnx3_q[FRAC_BITS+PIX_W-1:FRAC_BITS];
      ry4_q   <= mny3_q[FRAC_BITS+PIX_W-1:FRAC_BITS];
      cw4_q   <= cwr[SIZE_W-1:0];
      ch4_q   <= chr[SIZE_W-1:0];
    end
  end

  logic [SIZE_W-1:0] wlim, hlim;
  assign wlim = width_i - {1'b0, rx4_q};
  assign hlim = height_i - {1'b0, ry4_q};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      visible_o <= ~cull4_q;
      rect_x_o  <= cull4_q ? '0 : rx4_q;
      rect_y_o  <= cull4_q ? '0 : ry4_q;
      rect_w_o  <= cull4_q ? '0 : ((cw4_q > wlim) ? wlim : cw4_q);
      rect_h_o  <= cull4_q ? '0 : ((ch4_q > hlim) ? hlim : ch4_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  assign valid_o = v5_q;

endmodule

// ===== hw/rtl/projected_box_screen_bounds_unit.sv =====
// Throughput: one request per cycle; eight restoring dividers, one quotient
// bit per stage, keep the rate, and a stalled output freezes the whole pipe.
// Reset clears every valid bit and loads width 1280, height 720, focal 640.0.
// Depends on pbsb_pkg, pbsb_front, pbsb_div and pbsb_back.
module projected_box_screen_bounds_unit
  import pbsb_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [3:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [POS_W-1:0] pos_x_i,
  input  logic signed [POS_W-1:0] pos_y_i,
  input  logic signed [POS_W-1:0] pos_z_i,
  input  logic        [RAD_W-1:0] radius_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    visible_o,
  output logic [PIX_W-1:0]        rect_x_o,
  output logic [PIX_W-1:0]        rect_y_o,
  output logic [SIZE_W-1:0]       rect_w_o,
  output logic [SIZE_W-1:0]       rect_h_o
);

  localparam int NSH = (FRAC_BITS > FOC_FRAC) ? FRAC_BITS - FOC_FRAC : 0;
  localparam int DSH = (FRAC_BITS < FOC_FRAC) ? FOC_FRAC - FRAC_BITS : 0;
  localparam int NW  = CRD_W + FOC_W + NSH;
  localparam int DW  = POS_W + DSH;
  localparam int QB  = FRAC_BITS + SAT_LOG2 + 1;

  logic [SIZE_W-1:0] width_q, height_q;
  logic [FOC_W-1:0]  focal_q;
  logic              wr_en;
  pbsb_reg_e         reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = pbsb_reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      focal_q  <= FOCAL_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_WIDTH:  width_q  <= pwdata[SIZE_W-1:0];
        REG_HEIGHT: height_q <= pwdata[SIZE_W-1:0];
        REG_FOCAL:  focal_q  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_WIDTH:  prdata = 32'(width_q);
      REG_HEIGHT: prdata = 32'(height_q);
      REG_FOCAL:  prdata = focal_q;
      default:    prdata = '0;
    endcase
  end

  logic [SIZE_W-1:0] width_eff, height_eff;

  always_comb begin
    width_eff  = (width_q == '0) ? 13'd1 : ((width_q > MAX_SIZE) ? MAX_SIZE : width_q);
    height_eff = (height_q == '0) ? 13'd1 :
                 ((height_q > MAX_SIZE) ? MAX_SIZE : height_q);
  end

  logic en;
  assign en         = ~(out_valid_o & out_stall_i);
  assign in_stall_o = ~en;

  logic          fr_valid;
  pbsb_side_t    fr_side;
  logic [NW-1:0] fr_num [4];
  logic [DW-1:0] fr_den [2];

  pbsb_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (in_valid_i),
    .pos_x_i  (pos_x_i),
    .pos_y_i  (pos_y_i),
    .pos_z_i  (pos_z_i),
    .radius_i (radius_i),
    .focal_i  (focal_q),
    .valid_o  (fr_valid),
    .side_o   (fr_side),
    .num_o    (fr_num),
    .den_o    (fr_den)
  );

  logic [QB-1:0] quo [8];
  logic          sat [8];

  for (genvar k = 0; k < 8; k++) begin : g_lane
    pbsb_div #(
      .FRAC_BITS(FRAC_BITS)
    ) u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (fr_num[k>>1]),
      .den_i (fr_den[k&1]),
      .quo_o (quo[k]),
      .sat_o (sat[k])
    );
  end

  pbsb_side_t side_q [QB+1];
  logic       vld_q  [QB+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= fr_side;
      for (int i = 0; i < QB; i++) begin
        side_q[i+1] <= side_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= QB; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else if (en) begin
      vld_q[0] <= fr_valid;
      for (int i = 0; i < QB; i++) begin
        vld_q[i+1] <= vld_q[i];
      end
    end
  end

  pbsb_back #(
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (vld_q[QB]),
    .side_i    (side_q[QB]),
    .quo_i     (quo),
    .sat_i     (sat),
    .width_i   (width_eff),
    .height_i  (height_eff),
    .valid_o   (out_valid_o),
    .visible_o (visible_o),
    .rect_x_o  (rect_x_o),
    .rect_y_o  (rect_y_o),
    .rect_w_o  (rect_w_o),
    .rect_h_o  (rect_h_o)
  );

endmodule

// ===== verif/projected_box_screen_bounds_unit_test.sv =====
// Self-checking bench for projected_box_screen_bounds_unit: drives directed and random sphere
// requests, predicts each screen rectangle in a small scoreboard class, and walks several
// screen setups. Depends on pbsb_pkg and the unit RTL.
`timescale 1ns / 100ps

module projected_box_screen_bounds_unit_test;
  import pbsb_pkg::*;

  typedef struct packed {
    logic              visible;
    logic [PIX_W-1:0]  rx;
    logic [PIX_W-1:0]  ry;
    logic [SIZE_W-1:0] rw;
    logic [SIZE_W-1:0] rh;
  } rect_t;

  class rect_scoreboard;
    rect_t   pending[$];
    longint  width_reg = 1280, height_reg = 720, focal_reg = 41943040;
    int      errors = 0;

    function longint clamp_size(longint v);
      if (v == 0) return 1;
      if (v > 4096) return 4096;
      return v;
    endfunction

    function longint offset(longint c, longint z);
      logic [127:0] prod, quo;
      longint       a, q;
      longint       lim = longint'(1) << (16 + SAT_LOG2);
      if (c == 0) return 0;
      a = (c < 0) ? -c : c;
      if (z == 0) q = lim;
      else begin
        prod = 128'(a) * 128'(focal_reg);
        quo  = prod / 128'(z);
        q    = (quo > 128'(lim)) ? lim : longint'(quo);
      end
      return (c < 0) ? -q : q;
    endfunction

    function longint coord(longint c, longint z, longint size);
      if (z < 0) return (c < 0) ? -(longint'(1) << 16) : size << 16;
      return ((size / 2) << 16) + offset(c, z);
    endfunction

    function rect_t bounds(longint px, longint py, longint pz, longint r);
      rect_t  res;
      longint one = 1 << 16;
      longint w, h, minx, miny, maxx, maxy, sx, sy, cx, cy, cz, dx, dy, rx, ry, cw, ch;
      res = '0;
      w = clamp_size(width_reg);
      h = clamp_size(height_reg);
      minx = 64'h7fffffffffffffff; miny = minx; maxx = 0; maxy = 0;
      if (pz + r <= 0) return res;
      for (int i = 0; i < 8; i++) begin
        cx = px + ((i & 4) ? -r : r);
        cy = py + ((i & 1) ? -r : r);
        cz = pz + ((i & 2) ? -r : r);
        sx = coord(cx, cz, w);
        sy = coord(cy, cz, h);
        if (sx < minx) minx = sx;
        if (sx > maxx) maxx = sx;
        if (sy < miny) miny = sy;
        if (sy > maxy) maxy = sy;
      end
      if ((minx < 0 && maxx < 0) || (minx > w * one && maxx > w * one) ||
          (miny < 0 && maxy < 0) || (miny > h * one && maxy > h * one)) return res;
      if (minx < 0) minx = 0;
      if (minx > (w - 1) * one) minx = (w - 1) * one;
      if (miny < 0) miny = 0;
      if (miny > (h - 1) * one) miny = (h - 1) * one;
      if (maxx > w * one) maxx = w * one;
      if (maxy > h * one) maxy = h * one;
      dx = maxx - minx;
      dy = maxy - miny;
      if (dx < one / 2 || dy < one / 2) return res;
      rx = minx >>> 16;
      ry = miny >>> 16;
      cw = (dx + 2 * one - 1) >>> 16;
      ch = (dy + 2 * one - 1) >>> 16;
      if (cw > w - rx) cw = w - rx;
      if (ch > h - ry) ch = h - ry;
      res.visible = 1'b1;
      res.rx = rx[PIX_W-1:0];
      res.ry = ry[PIX_W-1:0];
      res.rw = cw[SIZE_W-1:0];
      res.rh = ch[SIZE_W-1:0];
      return res;
    endfunction

    function void note_request(logic signed [POS_W-1:0] px, logic signed [POS_W-1:0] py,
                               logic signed [POS_W-1:0] pz, logic [RAD_W-1:0] r);
      pending.insert(pending.size(),
                     bounds(longint'(px), longint'(py), longint'(pz), longint'(r)));
    endfunction

    function void check_result(rect_t got);
      rect_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.visible !== exp_r.visible) begin
        $display("%0t: visible exp %0d got %0d", $time, exp_r.visible, got.visible); errors++;
      end
      if (got.rx !== exp_r.rx) begin
        $display("%0t: rect_x exp %0d got %0d", $time, exp_r.rx, got.rx); errors++;
      end
      if (got.ry !== exp_r.ry) begin
        $display("%0t: rect_y exp %0d got %0d", $time, exp_r.ry, got.ry); errors++;
      end
      if (got.rw !== exp_r.rw) begin
        $display("%0t: rect_w exp %0d got %0d", $time, exp_r.rw, got.rw); errors++;
      end
      if (got.rh !== exp_r.rh) begin
        $display("%0t: rect_h exp %0d got %0d", $time, exp_r.rh, got.rh); errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0, rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  logic pready;
  logic in_valid_i = 1'b0, in_stall_o;
  logic signed [POS_W-1:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic [RAD_W-1:0] radius_i = '0;
  logic out_valid_o, out_stall_i = 1'b0;
  logic visible_o;
  logic [PIX_W-1:0] rect_x_o, rect_y_o;
  logic [SIZE_W-1:0] rect_w_o, rect_h_o;

  rect_scoreboard sb = new();
  int  idle_cycles = 0;
  bit  hold_req = 0;

  always #1 clk_i = ~clk_i;

  projected_box_screen_bounds_unit u_dut (.*);

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i)
      sb.check_result('{visible_o, rect_x_o, rect_y_o, rect_w_o, rect_h_o});
    if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles > 20000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int n;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i = 1'b1;
        repeat (300) @(negedge clk_i);
        hold_req = 0;
        out_stall_i = 1'b0;
      end else begin
        n = $urandom_range(0, 99);
        if (n < 40) out_stall_i = 1'b0;
        else begin
          out_stall_i = 1'b1;
          n = (n < 95) ? $urandom_range(1, 3) : $urandom_range(10, 60);
          repeat (n - 1) @(negedge clk_i);
        end
      end
    end
  end

  task automatic reg_write(pbsb_reg_e idx, logic [31:0] value);
    @(negedge clk_i);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = {idx, 2'b00}; pwdata = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    case (idx)
      REG_WIDTH:  sb.width_reg  = value & 32'h1fff;
      REG_HEIGHT: sb.height_reg = value & 32'h1fff;
      default:    sb.focal_reg  = value;
    endcase
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  task automatic send(logic signed [POS_W-1:0] px, logic signed [POS_W-1:0] py,
                      logic signed [POS_W-1:0] pz, logic [RAD_W-1:0] r, int gap);
    in_valid_i = 1'b0;
    repeat (gap) @(negedge clk_i);
    pos_x_i = px; pos_y_i = py; pos_z_i = pz; radius_i = r;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(px, py, pz, r);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  function automatic int pick_gap();
    int n = $urandom_range(0, 99);
    if (n < 55) return 0;
    if (n < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_random(int count, bit bursty);
    longint z, x, y, r;
    int     m;
    for (int i = 0; i < count; i++) begin
      m = $urandom_range(0, 9);
      if (m < 7) begin
        z = (longint'($urandom_range(0, 3000)) << 16) + $urandom_range(0, 65535);
        x = (longint'($urandom) % (z / 2 + 65536 * 8));
        y = (longint'($urandom) % (z / 2 + 65536 * 8));
        if (m == 0) z = -z;
        if ($urandom_range(0, 1)) x = -x;
        if ($urandom_range(0, 1)) y = -y;
        r = $urandom_range(0, 1) ? $urandom_range(0, 1 << 16) : longint'($urandom_range(0, 1 << 24));
        if (m == 1) z = r;
        send(x[47:0], y[47:0], z[47:0], r[46:0], bursty ? 0 : pick_gap());
      end else
        send(POS_W'({$urandom, $urandom}), POS_W'({$urandom, $urandom}),
             POS_W'({$urandom, $urandom}), RAD_W'({$urandom, $urandom}),
             bursty ? 0 : pick_gap());
    end
  endtask

  localparam logic signed [POS_W-1:0] PMAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] PMIN = {1'b1, {(POS_W-1){1'b0}}};
  localparam logic [RAD_W-1:0]        RMAX = '1;

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send(0, 0, 0, 0, 0);
    send(0, 0, -48'sd65536, 47'd65536, 0);
    send(48'sd100 << 16, 0, 48'sd10 << 16, 47'd10 << 16, 1);
    send(0, 0, 48'sd20 << 16, 47'd20 << 16, 0);
    send(-(48'sd5 << 16), 48'sd5 << 16, 48'sd1 << 16, 47'd1 << 16, 0);
    send(0, 0, 48'sd100 << 16, 47'd5 << 16, 0);
    send(0, 0, 48'sd1000 << 16, 47'd1, 0);
    send(48'sd100000 << 16, 0, 48'sd10 << 16, 47'd1 << 16, 2);
    send(0, -(48'sd100000 << 16), 48'sd10 << 16, 47'd1 << 16, 0);
    send(0, 0, -(48'sd10 << 16), 47'd20 << 16, 0);
    send(PMAX, PMAX, PMAX, 0, 0);
    send(PMIN, PMIN, PMIN, RMAX, 0);
    send(PMAX, PMIN, 48'sd1, RMAX, 0);
    send(PMIN, PMAX, PMAX, RMAX, 0);
    send(0, 0, PMAX, RMAX, 0);
    send(48'sd1, -48'sd1, 48'sd0, 47'd1, 0);
    send('1, '1, 48'sd3 << 16, 47'd2 << 16, 0);
    send(48'sd640 << 16, 48'sd360 << 16, 48'sd640 << 16, 47'd4 << 16, 0);
    send_random(150, 1'b0);
    hold_req = 1;
    send_random(80, 1'b1);
    drain();

    reg_write(REG_WIDTH, 32'd1);
    reg_write(REG_HEIGHT, 32'd1);
    reg_write(REG_FOCAL, 32'd0);
    send_random(140, 1'b0);
    drain();

    reg_write(REG_WIDTH, 32'd4096);
    reg_write(REG_HEIGHT, 32'd4096);
    reg_write(REG_FOCAL, 32'hffffffff);
    send_random(140, 1'b0);
    drain();

    reg_write(REG_WIDTH, 32'd0);
    reg_write(REG_HEIGHT, 32'h1fff);
    reg_write(REG_FOCAL, $urandom);
    send_random(140, 1'b0);
    drain();

    reg_write(REG_WIDTH, 32'd640);
    reg_write(REG_HEIGHT, 32'd480);
    reg_write(REG_FOCAL, 32'd500 << 16);
    send_random(150, 1'b0);
    drain();

    reg_write(REG_WIDTH, $urandom_range(1, 4096));
    reg_write(REG_HEIGHT, $urandom_range(1, 4096));
    reg_write(REG_FOCAL, $urandom_range(1, 4000) << 16);
    send_random(150, 1'b0);
    in_valid_i = 1'b0;
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== projected_box_screen_bounds_unit.f =====
hw/rtl/pbsb_pkg.sv
hw/rtl/pbsb_front.sv
hw/rtl/pbsb_div.sv
hw/rtl/pbsb_back.sv
hw/rtl/projected_box_screen_bounds_unit.sv
verif/projected_box_screen_bounds_unit_test.sv
